@@ rtl/olr_pkg.sv @@
`default_nettype none

package olr_pkg;

   localparam int CHAR_W  = 8;
   localparam int ADDR_W  = 15;
   localparam int DATA_W  = 8;
   localparam int VALUE_W = 24;
   localparam int COL_W   = 7;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_WRITE     = 2'd0;
   localparam kind_type KIND_LENGTH    = 2'd1;
   localparam kind_type KIND_START     = 2'd2;
   localparam kind_type KIND_OUT_RANGE = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_E     = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_CARET = 8'h5E;

   localparam logic [COL_W-1:0] COL_MAX         = 7'd127;
   localparam logic [COL_W-1:0] ADDR_FIRST_COL  = 7'd2;
   localparam logic [COL_W-1:0] ADDR_LAST_COL   = 7'd7;

   typedef struct packed {
      kind_type             kind;
      logic [ADDR_W-1:0]    address;
      logic [DATA_W-1:0]    data_byte;
      logic [VALUE_W-1:0]   value;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/olr_req_if.sv @@
`default_nettype none

interface olr_req_if;
   import olr_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

@@ rtl/olr_rsp_if.sv @@
`default_nettype none

interface olr_rsp_if;
   import olr_pkg::*;

   logic               valid;
   logic               ready;
   kind_type           kind;
   logic [ADDR_W-1:0]  address;
   logic [DATA_W-1:0]  data_byte;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output kind, output address, output data_byte,
                   output value, input ready);
   modport sink   (input valid, input kind, input address, input data_byte,
                   input value, output ready);
endinterface

`default_nettype wire

@@ rtl/object_record_loader.sv @@
`default_nettype none

// Absolute loader for a SIC-style object program. One text character enters per
// clock cycle while the request side is ready; its state update is a single pass
// of logic on the parse registers, and a result word (byte write, program length,
// start address or out-of-range address) is registered for the response channel.
// A two-word output buffer (result register plus skid register) lets characters
// keep flowing while a result waits; the request side stalls only when both
// words are held. Once the end record has been reported, all further characters
// are taken and ignored until reset.
module object_record_loader #(
   parameter int ADDRESS_BITS  = 15,
   parameter int DATA_COLUMN   = 12,
   parameter int LENGTH_COLUMN = 16
) (
   input  wire         clock,
   input  wire         reset,
   olr_req_if.sink     req_chan,
   olr_rsp_if.source   rsp_chan
);
   import olr_pkg::*;

   localparam logic [2:0] PH_HEADER     = 3'd0;
   localparam logic [2:0] PH_LINE       = 3'd1;
   localparam logic [2:0] PH_TEXT       = 3'd2;
   localparam logic [2:0] PH_TEXT_CARET = 3'd3;
   localparam logic [2:0] PH_ELINE      = 3'd4;

   localparam logic [COL_W-1:0] DATA_COL   = COL_W'(DATA_COLUMN);
   localparam logic [COL_W-1:0] LENGTH_COL = COL_W'(LENGTH_COLUMN);
   // Bits that must be clear for an address to fall inside memory.
   localparam logic [VALUE_W-1:0] RANGE_MASK =
      ~((VALUE_W'(1) << ADDRESS_BITS) - VALUE_W'(1));

   logic [2:0]         phase_ff, phase_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [VALUE_W-1:0] load_ff, load_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               stop_ff, stop_in;
   logic               pend_ff, pend_in;
   logic               fin_ff, fin_in;

   logic               out_valid_ff, skid_valid_ff;
   rsp_word_type       out_ff, skid_ff;

   logic [CHAR_W-1:0]  ch;
   logic               accept;
   logic               pop;
   logic               is_hex;
   logic [3:0]         digit;
   logic               is_ws;
   logic               res_valid;
   rsp_word_type       res;
   logic [VALUE_W-1:0] base_val;
   logic               base_stop;

   function automatic rsp_word_type make_write(input logic [VALUE_W-1:0] addr,
                                               input logic [DATA_W-1:0]  data);
      rsp_word_type w;
      w = '0;
      if ((addr & RANGE_MASK) != '0) begin
         w.kind  = KIND_OUT_RANGE;
         w.value = addr;
      end else begin
         w.kind      = KIND_WRITE;
         w.address   = addr[ADDR_W-1:0];
         w.data_byte = data;
      end
      return w;
   endfunction

   assign ch     = req_chan.char_code;
   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = out_valid_ff && rsp_chan.ready;

   assign req_chan.ready     = !skid_valid_ff;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kind      = out_ff.kind;
   assign rsp_chan.address   = out_ff.address;
   assign rsp_chan.data_byte = out_ff.data_byte;
   assign rsp_chan.value     = out_ff.value;

   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         digit = 4'(ch - 8'h30);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         digit = 4'(ch - 8'h37);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         digit = 4'(ch - 8'h57);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign is_ws = (ch == CHAR_SPACE) || (ch >= CHAR_TAB && ch <= CHAR_CR);

   always_comb begin
      phase_in  = phase_ff;
      col_in    = col_ff;
      load_in   = load_ff;
      acc_in    = acc_ff;
      stop_in   = stop_ff;
      pend_in   = pend_ff;
      fin_in    = fin_ff;
      res_valid = 1'b0;
      res       = '0;
      base_val  = '0;
      base_stop = 1'b0;

      if (fin_ff) begin
         // Everything after the end record is dropped.
      end else if (ch == CHAR_LF) begin
         if (col_ff != '0) begin
            if (phase_ff == PH_HEADER) begin
               res_valid = 1'b1;
               res.kind  = KIND_LENGTH;
               res.value = acc_ff;
            end else if (phase_ff == PH_ELINE) begin
               res_valid = 1'b1;
               res.kind  = KIND_START;
               res.value = load_ff;
               fin_in    = 1'b1;
            end else if (pend_ff && !stop_ff) begin
               // A lone digit left at the end of a line is written by itself.
               res_valid = 1'b1;
               res       = make_write(load_ff, acc_ff[DATA_W-1:0]);
               load_in   = load_ff + VALUE_W'(1);
            end
            phase_in = PH_LINE;
         end
         col_in  = '0;
         pend_in = 1'b0;
         stop_in = 1'b0;
      end else if (col_ff == '0 && is_ws) begin
         // Leading whitespace is skipped without counting a column.
      end else begin
         col_in = (col_ff < COL_MAX) ? col_ff + COL_W'(1) : COL_MAX;
         if (phase_ff == PH_HEADER) begin
            if (col_ff == LENGTH_COL) begin
               base_val  = '0;
               base_stop = 1'b0;
            end else begin
               base_val  = acc_ff;
               base_stop = stop_ff;
            end
            acc_in  = base_val;
            stop_in = base_stop;
            if (col_ff >= LENGTH_COL && !base_stop) begin
               if (!is_hex) begin
                  stop_in = 1'b1;
               end else begin
                  acc_in = {base_val[VALUE_W-5:0], digit};
               end
            end
         end else if (col_ff == '0) begin
            phase_in = (ch == CHAR_E) ? PH_ELINE : PH_TEXT;
         end else if (phase_ff != PH_ELINE && col_ff >= DATA_COL) begin
            if (!pend_ff) begin
               if (phase_ff == PH_TEXT_CARET && ch == CHAR_CARET) begin
                  phase_in = PH_TEXT;
               end else begin
                  phase_in = PH_TEXT;
                  pend_in  = 1'b1;
                  stop_in  = !is_hex;
                  acc_in   = is_hex ? VALUE_W'(digit) : '0;
               end
            end else begin
               pend_in  = 1'b0;
               phase_in = PH_TEXT_CARET;
               load_in  = load_ff + VALUE_W'(1);
               // A bad first digit drops the word but the address still moves on.
               if (!stop_ff) begin
                  res_valid = 1'b1;
                  res = make_write(load_ff,
                                   is_hex ? {acc_ff[3:0], digit} : acc_ff[DATA_W-1:0]);
               end
            end
         end else if (col_ff >= ADDR_FIRST_COL && col_ff <= ADDR_LAST_COL) begin
            if (col_ff == ADDR_FIRST_COL) begin
               base_val  = '0;
               base_stop = 1'b0;
            end else begin
               base_val  = load_ff;
               base_stop = stop_ff;
            end
            load_in = base_val;
            stop_in = base_stop;
            if (!base_stop) begin
               if (!is_hex) begin
                  stop_in = 1'b1;
               end else begin
                  load_in = {base_val[VALUE_W-5:0], digit};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         col_ff   <= '0;
         load_ff  <= '0;
         acc_ff   <= '0;
         stop_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         load_ff  <= load_in;
         acc_ff   <= acc_in;
         stop_ff  <= stop_in;
         pend_ff  <= pend_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept && res_valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept && res_valid) begin
         if (!out_valid_ff || pop) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   // The skid word is only ever filled behind a held result word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without a result word");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_chan.ready))
      else $error("skid word filled while result register was free");

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("end of program flag cleared without reset");

   a_no_pair_at_line_start: assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0) |-> !pend_ff)
      else $error("half a byte pending at the start of a line");

   a_write_word_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == KIND_WRITE) |-> (out_ff.value == '0))
      else $error("byte write word carries a value");

endmodule

`default_nettype wire
